@@ src/cld_pkg.sv @@
// shared types and constants of the crash-loop detector
package cld_pkg;

  // event actions; codes six and seven are unused and fall to default arms
  typedef enum logic [2:0] {
    ACT_CHECK    = 3'd0,
    ACT_RECORD   = 3'd1,
    ACT_STARTUP  = 3'd2,
    ACT_SHUTDOWN = 3'd3,
    ACT_EXIT     = 3'd4,
    ACT_QUERY    = 3'd5
  } action_t;

  // result status codes
  localparam logic [1:0] STATUS_NONE     = 2'd0;
  localparam logic [1:0] STATUS_DETECTED = 2'd1;
  localparam logic [1:0] STATUS_ACTIVE   = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_WINDOW     = 2'd0;
  localparam logic [1:0] REG_THRESHOLD  = 2'd1;
  localparam logic [1:0] REG_MIN_UPTIME = 2'd2;

  // configuration reset values
  localparam logic [31:0] WINDOW_RESET     = 32'd300;
  localparam logic [3:0]  THRESHOLD_RESET  = 4'd3;
  localparam logic [31:0] MIN_UPTIME_RESET = 32'd60;

  // field widths
  localparam int TIME_W  = 32;
  localparam int CODE_W  = 32;
  localparam int PHASE_W = 4;
  localparam int REC_W   = TIME_W + CODE_W + PHASE_W;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic scan;
    logic finish;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
  } dp_status_t;

endpackage

@@ src/crash_loop_detector_top.sv @@
// top level of the crash-loop detector
// one event at a time: accept, then a scan state that reads one stored record a cycle from the
// registered ring port and drains the last read, then a finish state that waits while an earlier
// result beat is stalled; a check on an empty ring or in safe mode, or any other event, scans no record
// result beat registered in the finish state and held until taken
// synchronous active-high reset: empty history, safe mode off, no startup, default registers
module crash_loop_detector_top #(
  parameter int HISTORY_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  action,
  input  logic [31:0] now_seconds,
  input  logic [31:0] exit_status,
  input  logic [3:0]  boot_phase,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic        safe_mode,
  output logic [3:0]  recent_count
);
  import cld_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t dp_status;

  // sequencing
  cld_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .dp_status (dp_status)
  );

  // registers, ring and scan
  cld_datapath #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .action        (action),
    .now_seconds   (now_seconds),
    .exit_status   (exit_status),
    .boot_phase    (boot_phase),
    .cmd           (cmd),
    .dp_status     (dp_status),
    .status        (status),
    .safe_mode     (safe_mode),
    .recent_count  (recent_count)
  );

endmodule

@@ src/cld_ram.sv @@
// generic single write port ram with registered read
module cld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ src/cld_ctrl.sv @@
// controller state machine of the crash-loop detector
module cld_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output cld_pkg::ctrl_cmd_t  cmd,
  input  cld_pkg::dp_status_t dp_status
);
  import cld_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  // state and output valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (dp_status.scan_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // wait for the output slot to free up
        if (!out_valid || !out_stall) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // output beat held until taken
  always_comb begin
    if (cmd.finish) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

@@ src/cld_datapath.sv @@
// datapath of the crash-loop detector: registers, history ring and scan counter
module cld_datapath #(
  parameter int HISTORY_DEPTH = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [1:0]                   cfg_index,
  input  logic [31:0]                  cfg_data,
  input  logic [2:0]                   action,
  input  logic [cld_pkg::TIME_W-1:0]   now_seconds,
  input  logic [cld_pkg::CODE_W-1:0]   exit_status,
  input  logic [cld_pkg::PHASE_W-1:0]  boot_phase,
  input  cld_pkg::ctrl_cmd_t           cmd,
  output cld_pkg::dp_status_t          dp_status,
  output logic [1:0]                   status,
  output logic                         safe_mode,
  output logic [3:0]                   recent_count
);
  import cld_pkg::*;

  localparam int AW   = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CW   = $clog2(HISTORY_DEPTH + 1);
  localparam int CMPW = (CW > 4) ? CW : 4;

  // configuration
  logic [31:0] window_seconds;
  logic [3:0]  loop_threshold;
  logic [31:0] min_uptime_seconds;

  // latched event
  action_t             cur_action;
  logic [TIME_W-1:0]   cur_now;
  logic [CODE_W-1:0]   cur_code;
  logic [PHASE_W-1:0]  cur_phase;

  // detector state
  logic [AW-1:0]       write_pointer;
  logic [AW-1:0]       write_pointer_next;
  logic [CW-1:0]       fill_count;
  logic [CW-1:0]       fill_count_next;
  logic                safe_mode_flag;
  logic                safe_mode_next;
  logic [TIME_W-1:0]   startup_time;

  // scan
  logic [CW-1:0]       scan_idx;
  logic                scan_pend;
  logic [CW-1:0]       scan_cnt;
  logic                scan_active;
  logic                scan_issue;
  logic                scan_hit;
  logic [REC_W-1:0]    rec_rdata;
  logic [TIME_W-1:0]   rec_time;

  // result
  logic [1:0]          status_next;
  logic [3:0]          recent_next;
  logic [CMPW-1:0]     cnt_ext;
  logic                ram_we;
  logic                uptime_ok;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      window_seconds     <= WINDOW_RESET;
      loop_threshold     <= THRESHOLD_RESET;
      min_uptime_seconds <= MIN_UPTIME_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_WINDOW:     window_seconds     <= cfg_data;
        REG_THRESHOLD:  loop_threshold     <= cfg_data[3:0];
        REG_MIN_UPTIME: min_uptime_seconds <= cfg_data;
        default: ;
      endcase
    end
  end

  // event latch
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur_action <= action_t'(action);
      cur_now    <= now_seconds;
      cur_code   <= exit_status;
      cur_phase  <= boot_phase;
    end
  end

  // history ring: time, code and phase of each crash
  assign ram_we = cmd.finish && (cur_action == ACT_RECORD);

  cld_ram #(
    .WIDTH (REC_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (write_pointer),
    .wdata ({cur_now, cur_code, cur_phase}),
    .raddr (scan_idx[AW-1:0]),
    .rdata (rec_rdata)
  );

  assign rec_time = rec_rdata[REC_W-1 -: TIME_W];

  // scan one stored record a cycle
  assign scan_active = (cur_action == ACT_CHECK) && !safe_mode_flag;
  assign scan_issue  = cmd.scan && scan_active && (scan_idx != fill_count);
  assign scan_hit    = scan_pend && (cur_now >= rec_time) &&
                       ((cur_now - rec_time) <= window_seconds);
  assign dp_status.scan_done = !scan_active || ((scan_idx == fill_count) && !scan_pend);

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_pend <= 1'b0;
    end else if (cmd.accept) begin
      scan_pend <= 1'b0;
    end else begin
      scan_pend <= scan_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      scan_idx <= '0;
      scan_cnt <= '0;
    end else begin
      if (scan_issue) begin
        scan_idx <= scan_idx + 1'b1;
      end
      if (scan_hit) begin
        scan_cnt <= scan_cnt + 1'b1;
      end
    end
  end

  // event effect and result
  assign cnt_ext   = CMPW'(scan_cnt);
  assign uptime_ok = (startup_time != '0) && (cur_now >= startup_time) &&
                     ((cur_now - startup_time) >= min_uptime_seconds);

  always_comb begin
    write_pointer_next = write_pointer;
    fill_count_next    = fill_count;
    safe_mode_next     = safe_mode_flag;
    status_next        = STATUS_NONE;
    recent_next        = 4'd0;
    case (cur_action)
      ACT_CHECK: begin
        if (safe_mode_flag) begin
          status_next = STATUS_ACTIVE;
        end else begin
          if (cnt_ext >= CMPW'(loop_threshold)) begin
            safe_mode_next = 1'b1;
            status_next    = STATUS_DETECTED;
          end
          // count saturates at fifteen on deep rings
          recent_next = (cnt_ext > CMPW'(15)) ? 4'hF : cnt_ext[3:0];
        end
      end
      ACT_RECORD: begin
        write_pointer_next = (write_pointer == AW'(HISTORY_DEPTH - 1)) ? '0
                                                                      : write_pointer + 1'b1;
        if (fill_count != CW'(HISTORY_DEPTH)) begin
          fill_count_next = fill_count + 1'b1;
        end
      end
      ACT_SHUTDOWN: begin
        if (uptime_ok) begin
          write_pointer_next = '0;
          fill_count_next    = '0;
          safe_mode_next     = 1'b0;
        end
      end
      ACT_EXIT: begin
        if (safe_mode_flag) begin
          write_pointer_next = '0;
          fill_count_next    = '0;
          safe_mode_next     = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // detector state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer  <= '0;
      fill_count     <= '0;
      safe_mode_flag <= 1'b0;
      startup_time   <= '0;
    end else if (cmd.finish) begin
      write_pointer  <= write_pointer_next;
      fill_count     <= fill_count_next;
      safe_mode_flag <= safe_mode_next;
      if (cur_action == ACT_STARTUP) begin
        startup_time <= cur_now;
      end
    end
  end

  // output beat payload
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status       <= status_next;
      safe_mode    <= safe_mode_next;
      recent_count <= recent_next;
    end
  end

endmodule

@@ src/cld_checker.sv @@
// port-level checks of the crash-loop detector and their binding
module cld_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] status,
  input logic       safe_mode,
  input logic [3:0] recent_count
);
  import cld_pkg::*;

  // one event at a time: an accepted beat closes the input
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while an event is in progress");

  // a detected loop always leaves safe mode set
  a_detect_sets_safe: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == STATUS_DETECTED) |-> safe_mode)
    else $error("loop detected without safe mode");

  // safe mode already active skips the scan
  a_active_no_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == STATUS_ACTIVE) |-> (safe_mode && recent_count == 4'd0))
    else $error("safe-mode-active beat with a count or flag clear");

  // status code three is never produced
  a_status_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status != 2'd3))
    else $error("illegal status code");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(status) && $stable(safe_mode) && $stable(recent_count)))
    else $error("stalled result beat changed");

endmodule

bind crash_loop_detector_top cld_checker u_cld_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .status       (status),
  .safe_mode    (safe_mode),
  .recent_count (recent_count)
);
